// ----- sv/schedule_table_expiry_engine_defines.svh -----
// Assertion macros for the schedule table expiry engine checker.
// No dependencies; included by the checker file only.
`ifndef SCHEDULE_TABLE_EXPIRY_ENGINE_DEFINES_SVH
`define SCHEDULE_TABLE_EXPIRY_ENGINE_DEFINES_SVH

// Clocked assertion, quiet while reset is held.
`define STEE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define STEE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/stee_pkg.sv -----
// Shared constants, opcodes and controller/datapath interface types.
// No dependencies.
package stee_pkg;
    localparam int NUM_TABLES = 4;
    localparam int MAX_POINTS = 8;
    localparam int MAX_RES    = 64;
    localparam int TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int NP_W       = $clog2(MAX_POINTS + 1);
    localparam int PT_DEPTH   = NUM_TABLES * MAX_POINTS;
    localparam int ADDR_W     = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int EMIT_W     = $clog2(MAX_RES + 1);
    localparam int MS_Q_W     = 23;
    localparam int SUM_W      = 44;
    localparam int RATE_W     = 20;
    localparam int PT_W       = 40;

    // floor(x / 1000) == (x * DIV1000_MUL) >> DIV1000_SH for any 32-bit x.
    localparam logic [28:0] DIV1000_MUL = 29'd274877907;
    localparam int          DIV1000_SH  = 38;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_START    = 3'd1;
    localparam logic [2:0] OP_STOP     = 3'd2;
    localparam logic [2:0] OP_WR_POINT = 3'd3;
    localparam logic [2:0] OP_WR_DESC  = 3'd4;

    localparam logic [RATE_W-1:0] RATE_RESET = 20'd1000;

    typedef struct packed {
        logic load;
        logic exec;
        logic tbl_clr;
        logic tbl_inc;
        logic step;
        logic rd;
        logic fire;
        logic wrap;
        logic stop_tbl;
        logic conv_go;
        logic conv_sel;
        logic cl_lat;
        logic commit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       start_ok;
        logic       active;
        logic       delay_nz;
        logic       delay_one;
        logic       np_ok;
        logic       due;
        logic       cycle_end;
        logic       repeating;
        logic       last_tbl;
        logic       conv_done;
    } t_sts;
endpackage

// ----- sv/stee_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/stee_conv.sv -----
// Millisecond to tick converter: rounds ms * rate / 1000 up in five steps.
// Depends on stee_pkg.
module stee_conv (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [31:0]                 i_ms,
    input  logic [stee_pkg::RATE_W-1:0] i_rate,
    output logic                        o_done,
    output logic [31:0]                 o_ticks
);
    import stee_pkg::*;

    // ms = q * 1000 + rem, so the ticks are q * rate + ceil(rem * rate / 1000).
    typedef enum logic [2:0] {
        C_IDLE, C_QUOT, C_SPLIT, C_LOW, C_LOWQ, C_SUM
    } t_cstep;

    t_cstep            r_step;
    logic [31:0]       r_ms;
    logic [RATE_W-1:0] r_rate;
    logic [MS_Q_W-1:0] r_q;
    logic [9:0]        r_rem;
    logic [SUM_W-1:0]  r_hi;
    logic [31:0]       r_lo;
    logic [SUM_W-1:0]  r_sum;
    logic              r_done;
    logic [31:0]       w_mul_in;
    logic [60:0]       w_mul;
    logic [31:0]       w_q_x1000;

    // One reciprocal multiply serves both divides by 1000.
    assign w_mul_in  = (r_step == C_QUOT) ? r_ms : r_lo;
    assign w_mul     = 61'(w_mul_in) * 61'(DIV1000_MUL);
    assign w_q_x1000 = 32'(r_q) * 32'd1000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= C_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_ms   <= i_ms;
                r_rate <= i_rate;
                r_step <= C_QUOT;
            end else begin
                case (r_step)
                    C_QUOT: begin
                        r_q    <= w_mul[DIV1000_SH +: MS_Q_W];
                        r_step <= C_SPLIT;
                    end
                    C_SPLIT: begin
                        r_rem  <= 10'(r_ms - w_q_x1000);
                        r_hi   <= SUM_W'(r_q) * SUM_W'(r_rate);
                        r_step <= C_LOW;
                    end
                    C_LOW: begin
                        // Add 999 so the divide rounds up.
                        r_lo   <= 32'(r_rem) * 32'(r_rate) + 32'd999;
                        r_step <= C_LOWQ;
                    end
                    C_LOWQ: begin
                        r_q    <= w_mul[DIV1000_SH +: MS_Q_W];
                        r_step <= C_SUM;
                    end
                    C_SUM: begin
                        r_sum  <= r_hi + SUM_W'(r_q);
                        r_done <= 1'b1;
                        r_step <= C_IDLE;
                    end
                    default: r_step <= C_IDLE;
                endcase
            end
        end
    end

    assign o_done  = r_done;
    assign o_ticks = (r_sum[SUM_W-1:32] != '0) ? 32'hFFFF_FFFF :
                     (r_sum[31:0] == 32'd0)     ? 32'd1 : r_sum[31:0];
endmodule

// ----- sv/stee_dp.sv -----
// Datapath: per-table timing state, expiry point RAM, converter, result output.
// Depends on stee_pkg, stee_ram, stee_conv.
module stee_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  stee_pkg::t_cmd              i_cmd,
    output stee_pkg::t_sts              o_sts,
    input  logic                        i_cfg_we,
    input  logic [stee_pkg::RATE_W-1:0] i_cfg_wdata,
    input  logic [2:0]                  i_op,
    input  logic [7:0]                  i_table_id,
    input  logic [2:0]                  i_point_index,
    input  logic [31:0]                 i_time_value,
    input  logic [7:0]                  i_task_id,
    input  logic [3:0]                  i_point_count,
    input  logic                        i_repeat_flag,
    output logic                        o_res_valid,
    output logic [7:0]                  o_task_id_res,
    output logic [1:0]                  o_table_id_res,
    output logic                        o_last
);
    import stee_pkg::*;

    logic [RATE_W-1:0] r_rate;
    logic [2:0]        r_op;
    logic [7:0]        r_tid;
    logic [2:0]        r_pi;
    logic [31:0]       r_tv;
    logic [7:0]        r_task;
    logic [3:0]        r_cnt_in;
    logic              r_rep_in;

    logic              r_active [NUM_TABLES];
    logic              r_repeat [NUM_TABLES];
    logic [NP_W-1:0]   r_np     [NUM_TABLES];
    logic [31:0]       r_dl     [NUM_TABLES];
    logic [31:0]       r_el     [NUM_TABLES];
    logic [31:0]       r_cl     [NUM_TABLES];
    logic [31:0]       r_sdur   [NUM_TABLES];
    logic [NP_W-1:0]   r_scnt   [NUM_TABLES];
    logic              r_srep   [NUM_TABLES];

    logic [TBL_W-1:0]  r_cur;
    logic [31:0]       r_cl_tmp;
    logic [EMIT_W-1:0] r_emit_cnt;
    logic              r_pend_v;
    logic [7:0]        r_pend_task;
    logic [1:0]        r_pend_tbl;
    logic              r_out_v;
    logic [7:0]        r_out_task;
    logic [1:0]        r_out_tbl;
    logic              r_out_last;

    logic              w_tbl_ok;
    logic [TBL_W-1:0]  w_tsel;
    logic [7:0]        w_cur_ext;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [PT_W-1:0]   w_rdata;
    logic [31:0]       w_conv_ms;
    logic              w_conv_done;
    logic [31:0]       w_conv_ticks;

    assign w_tbl_ok  = (r_tid < 8'(NUM_TABLES));
    assign w_tsel    = r_tid[TBL_W-1:0];
    assign w_cur_ext = 8'(r_cur);

    assign w_we    = i_cmd.exec && w_tbl_ok && (r_op == OP_WR_POINT)
                     && (32'(r_pi) < 32'(MAX_POINTS));
    assign w_waddr = ADDR_W'(ADDR_W'(w_tsel) * ADDR_W'(MAX_POINTS) + ADDR_W'(r_pi));
    assign w_raddr = ADDR_W'(ADDR_W'(r_cur) * ADDR_W'(MAX_POINTS) + ADDR_W'(r_np[r_cur]));

    stee_ram #(
        .WIDTH (PT_W),
        .DEPTH (PT_DEPTH)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata ({r_tv, r_task}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // A zero start delay counts as 1 ms.
    assign w_conv_ms = i_cmd.conv_sel ? ((r_tv == 32'd0) ? 32'd1 : r_tv) : r_sdur[w_tsel];

    stee_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.conv_go),
        .i_ms    (w_conv_ms),
        .i_rate  (r_rate),
        .o_done  (w_conv_done),
        .o_ticks (w_conv_ticks)
    );

    always_comb begin
        o_sts           = '0;
        o_sts.op        = r_op;
        o_sts.start_ok  = w_tbl_ok && (r_scnt[w_tsel] != '0) && (r_sdur[w_tsel] != 32'd0);
        o_sts.active    = r_active[r_cur];
        o_sts.delay_nz  = (r_dl[r_cur] != 32'd0);
        o_sts.delay_one = (r_dl[r_cur] == 32'd1);
        o_sts.np_ok     = (r_np[r_cur] < r_scnt[r_cur]);
        o_sts.due       = (w_rdata[PT_W-1:8] <= r_el[r_cur]);
        o_sts.cycle_end = (r_cl[r_cur] != 32'd0) && (r_el[r_cur] >= r_cl[r_cur]);
        o_sts.repeating = r_repeat[r_cur];
        o_sts.last_tbl  = (r_cur == TBL_W'(NUM_TABLES - 1));
        o_sts.conv_done = w_conv_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= RATE_RESET;
            r_cur      <= '0;
            r_emit_cnt <= '0;
            r_pend_v   <= 1'b0;
            r_out_v    <= 1'b0;
            for (int t = 0; t < NUM_TABLES; t++) begin
                r_active[t] <= 1'b0;
                r_repeat[t] <= 1'b0;
                r_np[t]     <= '0;
                r_dl[t]     <= '0;
                r_el[t]     <= '0;
                r_cl[t]     <= '0;
                r_sdur[t]   <= '0;
                r_scnt[t]   <= '0;
                r_srep[t]   <= 1'b0;
            end
        end else begin
            r_out_v <= 1'b0;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_op     <= i_op;
                r_tid    <= i_table_id;
                r_pi     <= i_point_index;
                r_tv     <= i_time_value;
                r_task   <= i_task_id;
                r_cnt_in <= i_point_count;
                r_rep_in <= i_repeat_flag;
            end
            if (i_cmd.exec && w_tbl_ok) begin
                case (r_op)
                    OP_STOP: begin
                        r_active[w_tsel] <= 1'b0;
                        r_repeat[w_tsel] <= 1'b0;
                        r_np[w_tsel]     <= '0;
                        r_dl[w_tsel]     <= '0;
                        r_el[w_tsel]     <= '0;
                        r_cl[w_tsel]     <= '0;
                    end
                    OP_WR_DESC: begin
                        r_sdur[w_tsel] <= r_tv;
                        r_scnt[w_tsel] <= (32'(r_cnt_in) > 32'(MAX_POINTS)) ?
                                          NP_W'(MAX_POINTS) : NP_W'(r_cnt_in);
                        r_srep[w_tsel] <= r_rep_in;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.tbl_clr) begin
                r_cur      <= '0;
                r_emit_cnt <= '0;
            end
            if (i_cmd.tbl_inc) begin
                r_cur <= r_cur + TBL_W'(1);
            end
            if (i_cmd.step) begin
                if (r_dl[r_cur] != 32'd0) begin
                    r_dl[r_cur] <= r_dl[r_cur] - 32'd1;
                    if (r_dl[r_cur] == 32'd1) begin
                        r_el[r_cur] <= '0;
                        r_np[r_cur] <= '0;
                    end
                end else if (r_el[r_cur] != 32'hFFFF_FFFF) begin
                    r_el[r_cur] <= r_el[r_cur] + 32'd1;
                end
            end
            if (i_cmd.fire) begin
                r_np[r_cur] <= r_np[r_cur] + NP_W'(1);
                if (32'(r_emit_cnt) < 32'(MAX_RES)) begin
                    // Hold one activation back so the final one can carry last.
                    r_emit_cnt  <= r_emit_cnt + EMIT_W'(1);
                    r_pend_v    <= 1'b1;
                    r_pend_task <= w_rdata[7:0];
                    r_pend_tbl  <= w_cur_ext[1:0];
                    if (r_pend_v) begin
                        r_out_v    <= 1'b1;
                        r_out_task <= r_pend_task;
                        r_out_tbl  <= r_pend_tbl;
                        r_out_last <= 1'b0;
                    end
                end
            end
            if (i_cmd.wrap) begin
                r_el[r_cur] <= '0;
                r_np[r_cur] <= '0;
            end
            if (i_cmd.stop_tbl) begin
                r_active[r_cur] <= 1'b0;
                r_np[r_cur]     <= '0;
                r_el[r_cur]     <= '0;
                r_dl[r_cur]     <= '0;
            end
            if (i_cmd.cl_lat) begin
                r_cl_tmp <= w_conv_ticks;
            end
            if (i_cmd.commit) begin
                r_active[w_tsel] <= 1'b1;
                r_repeat[w_tsel] <= r_srep[w_tsel];
                r_np[w_tsel]     <= '0;
                r_el[w_tsel]     <= '0;
                r_cl[w_tsel]     <= r_cl_tmp;
                r_dl[w_tsel]     <= w_conv_ticks;
            end
            if (i_cmd.flush && r_pend_v) begin
                r_out_v    <= 1'b1;
                r_out_task <= r_pend_task;
                r_out_tbl  <= r_pend_tbl;
                r_out_last <= 1'b1;
                r_pend_v   <= 1'b0;
            end
        end
    end

    assign o_res_valid    = r_out_v;
    assign o_task_id_res  = r_out_task;
    assign o_table_id_res = r_out_tbl;
    assign o_last         = r_out_last;
endmodule

// ----- sv/stee_ctrl.sv -----
// Controller: sequences item dispatch, the tick walk and the start conversion.
// Depends on stee_pkg.
module stee_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  stee_pkg::t_sts i_sts,
    output stee_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import stee_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_TBL, S_FREQ, S_FCHK, S_FIN, S_NEXT, S_END,
        S_CL, S_CLW, S_DL, S_DLW
    } t_state;

    t_state r_state, n_state;
    logic   r_wrap, n_wrap;

    always_comb begin
        n_state = r_state;
        n_wrap  = r_wrap;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.op == OP_TICK) begin
                    o_cmd.tbl_clr = 1'b1;
                    n_state       = S_TBL;
                end else if (i_sts.op == OP_START) begin
                    n_state = i_sts.start_ok ? S_CL : S_IDLE;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_TBL: begin
                n_wrap = 1'b0;
                if (!i_sts.active) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.step = 1'b1;
                    // Still in the start delay: nothing comes due.
                    n_state = (i_sts.delay_nz && !i_sts.delay_one) ? S_NEXT : S_FREQ;
                end
            end
            S_FREQ: begin
                if (i_sts.np_ok) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_FCHK;
                end else begin
                    n_state = r_wrap ? S_NEXT : S_FIN;
                end
            end
            S_FCHK: begin
                if (i_sts.due) begin
                    o_cmd.fire = 1'b1;
                    n_state    = S_FREQ;
                end else begin
                    n_state = r_wrap ? S_NEXT : S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.cycle_end && i_sts.repeating) begin
                    o_cmd.wrap = 1'b1;
                    n_wrap     = 1'b1;
                    n_state    = S_FREQ;
                end else if (i_sts.cycle_end) begin
                    o_cmd.stop_tbl = 1'b1;
                    n_state        = S_NEXT;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.last_tbl) begin
                    n_state = S_END;
                end else begin
                    o_cmd.tbl_inc = 1'b1;
                    n_state       = S_TBL;
                end
            end
            S_END: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            S_CL: begin
                o_cmd.conv_go = 1'b1;
                n_state       = S_CLW;
            end
            S_CLW: begin
                if (i_sts.conv_done) begin
                    o_cmd.cl_lat = 1'b1;
                    n_state      = S_DL;
                end
            end
            S_DL: begin
                o_cmd.conv_go  = 1'b1;
                o_cmd.conv_sel = 1'b1;
                n_state        = S_DLW;
            end
            S_DLW: begin
                o_cmd.conv_sel = 1'b1;
                if (i_sts.conv_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wrap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wrap  <= n_wrap;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ----- sv/schedule_table_expiry_engine.sv -----
// Schedule table expiry engine: controller plus datapath.
// Depends on stee_pkg, stee_ctrl, stee_dp.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item is done. Write, stop, unused and refused-start items go
// from dispatch straight back to idle. A start converts the duration and
// then the start delay from ms to ticks, each through a reciprocal multiply
// by 1/1000 in five register steps between a launch and a hand-off state. A
// tick walks the tables in order: an idle table or one still counting down
// its start delay fires nothing, an active one fires each expiry point that
// has come due, and a repeating table that wraps refires its points that
// are due again. Activations leave on o_res_valid, each for exactly one
// cycle, and must be taken then: there is no back-pressure. One activation
// is always held back inside so that the final one of a tick carries o_last;
// it appears in the cycle after the walk ends, when busy is already low. A
// tick with nothing due gives no result. The tick rate register may be
// written at any idle time.
module schedule_table_expiry_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [stee_pkg::RATE_W-1:0] i_cfg_wdata,
    input  logic [2:0]                  i_op,
    input  logic [7:0]                  i_table_id,
    input  logic [2:0]                  i_point_index,
    input  logic [31:0]                 i_time_value,
    input  logic [7:0]                  i_task_id,
    input  logic [3:0]                  i_point_count,
    input  logic                        i_repeat_flag,
    output logic                        o_res_valid,
    output logic [7:0]                  o_task_id_res,
    output logic [1:0]                  o_table_id_res,
    output logic                        o_last
);
    import stee_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencing only; all state that the ops touch lives in the datapath.
    stee_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    stee_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_op),
        .i_table_id     (i_table_id),
        .i_point_index  (i_point_index),
        .i_time_value   (i_time_value),
        .i_task_id      (i_task_id),
        .i_point_count  (i_point_count),
        .i_repeat_flag  (i_repeat_flag),
        .o_res_valid    (o_res_valid),
        .o_task_id_res  (o_task_id_res),
        .o_table_id_res (o_table_id_res),
        .o_last         (o_last)
    );
endmodule

// ----- sv/stee_checker.sv -----
// Port-level checker for the expiry engine, bound to the top level.
// Depends on stee_pkg and schedule_table_expiry_engine_defines.svh.
`include "schedule_table_expiry_engine_defines.svh"

module stee_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] i_op,
    input logic       o_res_valid,
    input logic       o_last
);
    import stee_pkg::*;

    `STEE_ASSERT(a_accept_busy, start && !busy |=> busy, "busy low after accepted item")
    `STEE_ASSERT(a_last_ends, o_res_valid && o_last |=> !o_res_valid, "result after last")
    `STEE_ASSERT(a_cmd_silent, start && !busy && (i_op != OP_TICK) |=> !o_res_valid,
        "result right after non-tick item")
    `STEE_ASSERT_RST(a_reset_idle, !i_rst_n |=> !busy && !o_res_valid, "not idle after reset")
endmodule

bind schedule_table_expiry_engine stee_checker u_stee_checker (.*);
